### hw/rtl/pcbd_pkg.sv
// Shared types, constants and helpers for the power-of-two box downscaler.
// No dependencies; the cascade, the result queue, the top level and the test files import this package.
`default_nettype none

package pcbd_pkg;

    localparam int MAX_LEVELS = 4;
    localparam int QDEPTH     = 4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_LEVEL_MASK = 3'd2;
    localparam logic [2:0] CFG_OUT_W_L0   = 3'd3;
    localparam logic [2:0] CFG_OUT_W_L1   = 3'd4;
    localparam logic [2:0] CFG_OUT_W_L2   = 3'd5;
    localparam logic [2:0] CFG_OUT_W_L3   = 3'd6;

    localparam logic [11:0] OW_MASK [MAX_LEVELS] = '{12'hFFF, 12'h7FF, 12'h3FF, 12'h1FF};
    localparam logic [11:0] OW_RESET [MAX_LEVELS] = '{12'd2048, 12'd1024, 12'd512, 12'd256};

    typedef struct packed {
        logic [10:0] row;
        logic [10:0] col;
        logic [1:0]  level;
        logic [7:0]  pixel;
    } res_t;

    // All results caused by one input pixel, one slot per level.
    typedef struct packed {
        logic [MAX_LEVELS-1:0] vld;
        res_t [MAX_LEVELS-1:0] res;
    } group_t;

    function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pcbd_line_ram.sv
// One line store of the vertical cascade: synchronous RAM, one write and
// one registered read port. Depends on nothing.
`default_nettype none

module pcbd_line_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/pcbd_cascade.sv
// Second pipeline stage: vertical and horizontal averaging cascades, the
// horizontal partial registers and the emission rule. Uses pcbd_pkg.
`default_nettype none

module pcbd_cascade #(
    parameter int LEVELS = 4,
    parameter int CW     = 13,
    parameter int EW     = 13
) (
    input  wire logic                   clk,
    input  wire logic                   s1_valid,
    input  wire logic [CW-1:0]          x,
    input  wire logic [12:0]            y,
    input  wire logic [7:0]             pix,
    input  wire logic [7:0]             hold [LEVELS],
    input  wire logic [CW-1:0]          w_eff,
    input  wire logic [12:0]            h_eff,
    input  wire logic [3:0]             mask,
    input  wire logic [11:0]            ow [LEVELS],
    output logic                        wr [LEVELS],
    output logic      [7:0]             wr_data [LEVELS],
    output logic                        push,
    output pcbd_pkg::group_t            grp
);

    import pcbd_pkg::*;

    logic [7:0] partial_reg [LEVELS][LEVELS];
    logic [7:0] vval [LEVELS];
    logic       vok  [LEVELS];
    logic [7:0] hres [LEVELS];
    logic       hok  [LEVELS];
    logic       pwr  [LEVELS][LEVELS];
    logic [7:0] pwd  [LEVELS][LEVELS];
    logic       emit [LEVELS];
    logic [1:0] deepest;
    logic       rows_ok;

    // Vertical cascade: levels below the first even row bit are read,
    // the first level with an even row bit stores the running average.
    always_comb
    begin
        logic       chain;
        logic [7:0] v;
        chain = 1'b1;
        v     = pix;
        for (int k = 0; k < LEVELS; k++)
        begin
            wr[k]      = 1'b0;
            wr_data[k] = v;
            vok[k]     = 1'b0;
            vval[k]    = v;
            if (chain)
            begin
                if (!y[k])
                begin
                    wr[k] = s1_valid;
                    chain = 1'b0;
                end
                else
                begin
                    v       = avg2(hold[k], v);
                    vval[k] = v;
                    vok[k]  = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic [7:0] hv;
        logic       open;
        for (int k = 0; k < LEVELS; k++)
        begin
            hv   = vval[k];
            open = 1'b1;
            for (int s = 0; s < LEVELS; s++)
            begin
                pwr[k][s] = 1'b0;
                pwd[k][s] = hv;
                if (s <= k && open)
                begin
                    if (!x[s])
                    begin
                        pwr[k][s] = s1_valid && vok[k];
                        open      = 1'b0;
                    end
                    else
                    begin
                        hv = avg2(partial_reg[k][s], hv);
                    end
                end
            end
            hres[k] = hv;
            hok[k]  = open;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LEVELS; k++)
        begin
            for (int s = 0; s < LEVELS; s++)
            begin
                if (pwr[k][s])
                begin
                    partial_reg[k][s] <= pwd[k][s];
                end
            end
        end
    end

    // Rows count only inside complete row groups of the deepest enabled level.
    always_comb
    begin
        deepest = 2'd0;
        for (int k = 0; k < LEVELS; k++)
        begin
            if (mask[k])
            begin
                deepest = 2'(k);
            end
        end
        rows_ok = (y >> (deepest + 3'd1)) < (h_eff >> (deepest + 3'd1));
    end

    always_comb
    begin
        logic [EW-1:0] c;
        logic [EW-1:0] lim;
        logic [EW-1:0] lw;
        logic [12:0]   r;
        grp = '0;
        for (int k = 0; k < LEVELS; k++)
        begin
            c   = EW'(x >> (k + 1));
            lw  = EW'(w_eff >> (k + 1));
            lim = (EW'(ow[k]) < lw) ? EW'(ow[k]) : lw;
            r   = y >> (k + 1);
            emit[k] = vok[k] && hok[k] && mask[k] && rows_ok && (c < lim);
            grp.vld[k]       = emit[k];
            grp.res[k].pixel = hres[k];
            grp.res[k].level = 2'(k);
            grp.res[k].col   = c[10:0];
            grp.res[k].row   = r[10:0];
        end
    end

    assign push = s1_valid && (grp.vld != '0);

endmodule

`default_nettype wire

### hw/rtl/pcbd_out_queue.sv
// Result queue: holds per-pixel result groups and sends them one result
// per request on the output stream. Uses pcbd_pkg.
`default_nettype none

module pcbd_out_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire pcbd_pkg::group_t grp,
    output logic [2:0]            count,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata,   // out_pixel[7:0], level[9:8], out_col[20:10], out_row[31:21]
    output logic                  m_tlast
);

    import pcbd_pkg::*;

    group_t     mem_reg [QDEPTH];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] count_reg, count_next;
    logic [3:0] sent_reg, sent_next;
    logic [3:0] rem, pick, after;
    logic [1:0] idx;
    logic       pop, fire;
    group_t     head;

    assign head = mem_reg[rptr_reg];
    assign rem  = head.vld & ~sent_reg;
    assign pick = rem & (~rem + 4'd1);
    assign after = rem & ~pick;

    always_comb
    begin
        idx = 2'd0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--)
        begin
            if (pick[i])
            begin
                idx = 2'(i);
            end
        end
    end

    assign m_tvalid = (count_reg != 3'd0);
    assign m_tlast  = (after == 4'd0);
    assign m_tdata  = head.res[idx];
    assign fire     = m_tvalid && m_tready;
    assign pop      = fire && m_tlast;
    assign count    = count_reg;

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 2'd1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 2'd1 : rptr_reg;
        count_next = count_reg + {2'd0, push} - {2'd0, pop};
        sent_next  = sent_reg;
        if (pop)
        begin
            sent_next = 4'd0;
        end
        else if (fire)
        begin
            sent_next = sent_reg | pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 3'd0;
            sent_reg  <= 4'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
            sent_reg  <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= grp;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pow2_cascade_box_downscale.sv
// Top level of the power-of-two box downscaler: position counters, the
// line stores with forwarding, configuration registers. Uses pcbd_pkg,
// pcbd_line_ram, pcbd_cascade and pcbd_out_queue.
//
// Usage: one 8-bit plane enters on the s_ stream in raster order, one pixel
// per request in s_tdata, with s_tuser high on the first pixel of a frame.
// Downscaled pixels of the enabled levels (2x, 4x, 8x, 16x) leave on the m_
// stream, one result per request, tagged with level, column and row; m_tlast
// marks the last result caused by one input pixel. Configuration is written
// through cfg_we / cfg_addr / cfg_wdata while the block is idle.
// Timing: a pixel accepted at an edge reads the line stores at that edge, is
// averaged in the following cycle and written into the result queue, which
// presents its first result. Input takes one pixel per cycle while the result
// queue has room. A pixel may cause up to four results and they leave one per
// cycle while m_tready is high, so a run of pixels with several results each
// slows the input. Results of up to four pixels are queued; when the receiver
// stalls the queue fills and s_tready drops until room returns. Reset clears
// the counters, the queue and the configuration to its defaults; line store
// contents are left as they are and get written before they are read in a frame.
`default_nettype none

module pow2_cascade_box_downscale #(
    parameter int MAX_WIDTH = 4096,
    parameter int LEVELS    = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // pixel[7:0]
    input  wire logic        s_tuser,   // frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_pixel[7:0], level[9:8], out_col[20:10], out_row[31:21]
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [12:0] cfg_wdata
);

    import pcbd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;
    localparam int EW = (CW > 13) ? CW : 13;

    logic [12:0]   src_width_reg;
    logic [12:0]   src_height_reg;
    logic [3:0]    level_mask_reg;
    logic [11:0]   ow_reg [LEVELS];

    logic [CW-1:0] col_reg, col_next;
    logic [12:0]   row_reg, row_next;
    logic [CW-1:0] w_eff;
    logic [12:0]   h_eff;
    logic [3:0]    mask;
    logic          accept;

    logic          s1_valid_reg;
    logic [CW-1:0] s1_x_reg;
    logic [12:0]   s1_y_reg;
    logic [7:0]    s1_pix_reg;

    logic [7:0]    rd    [LEVELS];
    logic [7:0]    hold  [LEVELS];
    logic          wr    [LEVELS];
    logic [7:0]    wr_data [LEVELS];
    logic          fwd_reg [LEVELS];
    logic [7:0]    fwd_data_reg [LEVELS];

    logic          push;
    group_t        grp;
    logic [2:0]    qcount;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 13'd4096;
            src_height_reg <= 13'd4096;
            level_mask_reg <= 4'd1;
            for (int k = 0; k < LEVELS; k++)
            begin
                ow_reg[k] <= OW_RESET[k];
            end
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_wdata;
                CFG_SRC_HEIGHT: src_height_reg <= cfg_wdata;
                CFG_LEVEL_MASK: level_mask_reg <= cfg_wdata[3:0];
                CFG_OUT_W_L0:   if (LEVELS > 0) ow_reg[0] <= cfg_wdata[11:0] & OW_MASK[0];
                CFG_OUT_W_L1:   if (LEVELS > 1) ow_reg[1 % LEVELS] <= cfg_wdata[11:0] & OW_MASK[1];
                CFG_OUT_W_L2:   if (LEVELS > 2) ow_reg[2 % LEVELS] <= cfg_wdata[11:0] & OW_MASK[2];
                CFG_OUT_W_L3:   if (LEVELS > 3) ow_reg[3 % LEVELS] <= cfg_wdata[11:0] & OW_MASK[3];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        logic [EW-1:0] sw;
        sw = EW'(src_width_reg);
        if (sw == '0)
        begin
            sw = EW'(1);
        end
        else if (sw > EW'(MAX_WIDTH))
        begin
            sw = EW'(MAX_WIDTH);
        end
        w_eff = CW'(sw);
        h_eff = (src_height_reg == 13'd0) ? 13'd1 : src_height_reg;
        mask  = level_mask_reg & 4'(((1 << LEVELS) - 1));
    end

    // Each queued group needs a slot; the pixel in the second stage may
    // still push one.
    assign s_tready = (qcount + {2'd0, s1_valid_reg}) < 3'(QDEPTH);
    assign accept   = s_tvalid && s_tready;

    // Position of the incoming pixel, with wrap at the row and frame ends.
    always_comb
    begin
        col_next = s_tuser ? '0 : col_reg;
        row_next = s_tuser ? 13'd0 : row_reg;
        if (col_next >= w_eff)
        begin
            col_next = '0;
            row_next = row_next + 13'd1;
        end
        if (row_next >= h_eff)
        begin
            row_next = 13'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= 13'd0;
            s1_valid_reg <= 1'b0;
            for (int k = 0; k < LEVELS; k++)
            begin
                fwd_reg[k] <= 1'b0;
            end
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next + CW'(1);
                row_reg <= row_next;
            end
            // A write in the second stage to the column being read now
            // is missed by the RAM read, so it is carried along.
            for (int k = 0; k < LEVELS; k++)
            begin
                fwd_reg[k] <= accept && wr[k] && (col_next == s1_x_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg   <= col_next;
            s1_y_reg   <= row_next;
            s1_pix_reg <= s_tdata;
        end
        for (int k = 0; k < LEVELS; k++)
        begin
            fwd_data_reg[k] <= wr_data[k];
        end
    end

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_line
        pcbd_line_ram #(
            .DEPTH (MAX_WIDTH),
            .AW    (AW)
        ) u_ram (
            .clk   (clk),
            .we    (wr[g]),
            .waddr (s1_x_reg[AW-1:0]),
            .wdata (wr_data[g]),
            .re    (accept),
            .raddr (col_next[AW-1:0]),
            .rdata (rd[g])
        );
        assign hold[g] = fwd_reg[g] ? fwd_data_reg[g] : rd[g];
    end

    pcbd_cascade #(
        .LEVELS (LEVELS),
        .CW     (CW),
        .EW     (EW)
    ) u_cascade (
        .clk      (clk),
        .s1_valid (s1_valid_reg),
        .x        (s1_x_reg),
        .y        (s1_y_reg),
        .pix      (s1_pix_reg),
        .hold     (hold),
        .w_eff    (w_eff),
        .h_eff    (h_eff),
        .mask     (mask),
        .ow       (ow_reg),
        .wr       (wr),
        .wr_data  (wr_data),
        .push     (push),
        .grp      (grp)
    );

    pcbd_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .grp      (grp),
        .count    (qcount),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/pcbd_checker.sv
// Port-level checks for the box downscaler, attached to the top level by
// the bind at the end. Depends only on the top level's ports.
`default_nettype none

module pcbd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Results of one pixel come in rising level order without a gap.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[9:8] > $past(m_tdata[9:8])))
        else $error("results of one pixel out of level order");

    // With no result waiting the queue has room.
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A result shows up on an idle output only after an accepted input request.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a pixel");

endmodule

bind pow2_cascade_box_downscale pcbd_checker u_pcbd_checker (.*);

`default_nettype wire

### test/pow2_cascade_box_downscale_chk.sv
// Checker for the power-of-two box downscaler: watches configuration writes,
// input and output requests, predicts each downscaled pixel and compares.
// Depends on pcbd_pkg for register indexes, output width masks and reset widths.
`timescale 1ns / 100ps

module pow2_cascade_box_downscale_chk
    import pcbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel[7:0]
    input  logic        s_tuser,   // frame_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // out_pixel[7:0], level[9:8], out_col[20:10], out_row[31:21]
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [12:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    localparam int LINE_W = 4096;

    typedef struct {
        logic [7:0]  pix;
        logic [1:0]  lvl;
        logic [10:0] col;
        logic [10:0] row;
        logic        last;
    } scaled_pix_t;

    scaled_pix_t scaled_q[$];

    logic [7:0]  line_hold [4][LINE_W];
    logic [7:0]  col_partial [10];
    int unsigned col_pos, row_pos;
    logic [12:0] width_reg, height_reg;
    logic [3:0]  mask_reg;
    logic [11:0] out_w [4];

    function automatic logic [7:0] round_avg(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

    task automatic downscale_pixel(input logic [7:0] pix, input logic fs);
        int unsigned w, h, x, y, r, base, c, lim;
        logic [7:0]  v;
        logic [7:0]  vsum [4];
        bit          vdone [4];
        bit          done;
        int          deepest, n;
        scaled_pix_t found [4];

        w = width_reg;
        if (w < 1) w = 1;
        if (w > LINE_W) w = LINE_W;
        h = height_reg;
        if (h < 1) h = 1;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        x = col_pos;
        y = row_pos;

        // Even rows of each vertical stage are stored; odd rows average down.
        for (int k = 0; k < 4; k++) vdone[k] = 0;
        v = pix;
        r = y;
        for (int k = 0; k < 4; k++)
        begin
            if (r[0] == 1'b0)
            begin
                line_hold[k][x] = v;
                break;
            end
            v = round_avg(line_hold[k][x], v);
            vsum[k] = v;
            vdone[k] = 1;
            r = r >> 1;
        end

        deepest = -1;
        for (int k = 0; k < 4; k++)
            if (mask_reg[k]) deepest = k;

        n = 0;
        for (int k = 0; k < 4; k++)
        begin
            if (!vdone[k]) continue;
            base = k * (k + 1) / 2;
            done = 1;
            v = vsum[k];
            for (int s = 0; s <= k; s++)
            begin
                if (((x >> s) & 1) == 0)
                begin
                    col_partial[base + s] = v;
                    done = 0;
                    break;
                end
                v = round_avg(col_partial[base + s], v);
            end
            if (!done || !mask_reg[k]) continue;
            if ((y >> (deepest + 1)) >= (h >> (deepest + 1))) continue;
            c = x >> (k + 1);
            lim = w >> (k + 1);
            if (out_w[k] < lim) lim = out_w[k];
            if (c >= lim) continue;
            found[n].pix = v;
            found[n].lvl = k[1:0];
            found[n].col = c[10:0];
            found[n].row = 11'(y >> (k + 1));
            found[n].last = 0;
            n++;
        end
        if (n > 0) found[n - 1].last = 1;
        for (int i = 0; i < n; i++) scaled_q.push_back(found[i]);
        col_pos = x + 1;
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scaled_pix_t e;
        if (!rst_n)
        begin
            scaled_q.delete();
            col_pos = 0;
            row_pos = 0;
            width_reg = 13'd4096;
            height_reg = 13'd4096;
            mask_reg = 4'd1;
            for (int i = 0; i < 4; i++) out_w[i] = OW_RESET[i];
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_SRC_WIDTH:  width_reg = cfg_wdata;
                    CFG_SRC_HEIGHT: height_reg = cfg_wdata;
                    CFG_LEVEL_MASK: mask_reg = cfg_wdata[3:0];
                    CFG_OUT_W_L0:   out_w[0] = cfg_wdata[11:0] & OW_MASK[0];
                    CFG_OUT_W_L1:   out_w[1] = cfg_wdata[11:0] & OW_MASK[1];
                    CFG_OUT_W_L2:   out_w[2] = cfg_wdata[11:0] & OW_MASK[2];
                    CFG_OUT_W_L3:   out_w[3] = cfg_wdata[11:0] & OW_MASK[3];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) downscale_pixel(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
            begin
                if (scaled_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    e = scaled_q.pop_front();
                    check_field("out_pixel", e.pix, m_tdata[7:0]);
                    check_field("level", e.lvl, m_tdata[9:8]);
                    check_field("out_col", e.col, m_tdata[20:10]);
                    check_field("out_row", e.row, m_tdata[31:21]);
                    check_field("last", e.last, m_tlast);
                end
            end
        end
        pending = scaled_q.size();
    end

endmodule

### test/pow2_cascade_box_downscale_tb.sv
// Top of the downscaler testbench: clock, reset, configuration phases,
// pixel stimulus with random idling and the verdict.
// Depends on pcbd_pkg, the block and pow2_cascade_box_downscale_chk.
`timescale 1ns / 100ps

module pow2_cascade_box_downscale_tb;
    import pcbd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // pixel[7:0]
    logic        s_tuser;   // frame_start
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // out_pixel[7:0], level[9:8], out_col[20:10], out_row[31:21]
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [12:0] cfg_wdata;
    int          fail_count;
    int          pending;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          random_pixels;
    int          hold_left;
    bit          hold_done;
    bit          hold_go;

    pow2_cascade_box_downscale u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    pow2_cascade_box_downscale_chk u_chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The receiver stalls at random and, once, holds off long enough for the
    // block to fill up and stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
            hold_done = 0;
        end
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done = 1;
            hold_left = 300;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pixel(input logic [7:0] pix, input logic fs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= fs;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits for the block to drain, then loads one geometry.
    task automatic load_geometry(input logic [12:0] w, input logic [12:0] h,
                                 input logic [3:0] mask, input logic [12:0] ow [4]);
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_LEVEL_MASK, {9'd0, mask});
        write_reg(CFG_OUT_W_L0, ow[0]);
        write_reg(CFG_OUT_W_L1, ow[1]);
        write_reg(CFG_OUT_W_L2, ow[2]);
        write_reg(CFG_OUT_W_L3, ow[3]);
    endtask

    initial
    begin
        #20_000_000;
        $display("pow2_cascade_box_downscale regression: fail");
        $finish;
    end

    initial
    begin
        logic [12:0] ow [4];
        int          w, h, npix;
        logic [3:0]  mask;

        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        send_idle_pct = 6;
        recv_idle_pct = 63;
        random_pixels = 0;
        hold_go = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two levels on a 4x4 frame with pixel values 0xFF, 0x00 and 0xA5.
        ow = '{13'd4095, 13'd2047, 13'd1023, 13'd511};
        load_geometry(13'd4, 13'd4, 4'b0011, ow);
        for (int i = 0; i < 16; i++)
            send_pixel((i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'hA5), i == 0);

        // Zero width and height fall back to one, so nothing completes.
        ow = '{13'd0, 13'd0, 13'd0, 13'd0};
        load_geometry(13'd0, 13'd0, 4'hF, ow);
        for (int i = 0; i < 4; i++) send_pixel(8'h5A, i == 0);

        // Empty mask: the cascades run but no result leaves.
        ow = '{13'd2048, 13'd1024, 13'd512, 13'd256};
        load_geometry(13'd4, 13'd4, 4'b0000, ow);
        for (int i = 0; i < 5; i++) send_pixel(8'hC3, i == 0);

        // Two rows at 2x while the receiver holds off, so the queue fills
        // and the input stalls.
        ow = '{13'd4095, 13'd2047, 13'd1023, 13'd511};
        load_geometry(13'd32, 13'd2, 4'b0001, ow);
        hold_go = 1;
        for (int i = 0; i < 64; i++) send_pixel(8'($urandom_range(255)), i == 0);

        while (random_pixels < 370)
        begin
            if (random_pixels >= 217)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (random_pixels >= 64)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 6;
            end
            w = $urandom_range(1, 40);
            h = $urandom_range(1, 36);
            mask = $urandom_range(0, 7) == 0 ? 4'd0 : 4'($urandom_range(1, 15));
            for (int k = 0; k < 4; k++)
            begin
                case ($urandom_range(3))
                    0: ow[k] = 13'd0;
                    1: ow[k] = {1'b0, OW_MASK[k]};
                    default: ow[k] = 13'($urandom_range(1, 24));
                endcase
            end
            load_geometry(13'(w), 13'(h), mask, ow);
            npix = w * h + $urandom_range(0, w * h);
            if (npix > 160) npix = 160;
            if (npix > 370 - random_pixels) npix = 370 - random_pixels;
            for (int i = 0; i < npix; i++)
            begin
                send_pixel(8'($urandom_range(255)), i == 0 || $urandom_range(59) == 0);
                random_pixels++;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("pow2_cascade_box_downscale regression: pass");
        else
            $display("pow2_cascade_box_downscale regression: fail");
        $finish;
    end

endmodule

### pow2_cascade_box_downscale.f
hw/rtl/pcbd_pkg.sv
hw/rtl/pcbd_line_ram.sv
hw/rtl/pcbd_cascade.sv
hw/rtl/pcbd_out_queue.sv
hw/rtl/pow2_cascade_box_downscale.sv
hw/rtl/pcbd_checker.sv
test/pow2_cascade_box_downscale_chk.sv
test/pow2_cascade_box_downscale_tb.sv
